/* hdl/assert_macros.svh */
// Assertion macros used by the validator unit.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define UEV_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the following cycle.
`define UEV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/uev_pkg.sv */
package uev_pkg;

    // Default capacity of the edge counter.
    localparam int unsigned MAX_EDGES_DEF = 16;

    // Field widths.
    localparam int unsigned REQ_W      = 3;
    localparam int unsigned TS_W       = 32;
    localparam int unsigned VERDICT_W  = 3;
    localparam int unsigned EDGES_W    = 5;
    localparam int unsigned PULSES_W   = 5;
    localparam int unsigned BUZ_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_BURST_START = 3'd0,
        REQ_BURST_END   = 3'd1,
        REQ_ECHO_EDGE   = 3'd2,
        REQ_TICK        = 3'd3,
        REQ_EVALUATE    = 3'd4,
        REQ_STOP        = 3'd5
    } req_t;

    // Verdict codes.
    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_NONE       = 3'd0,
        VERDICT_ACCEPTED   = 3'd1,
        VERDICT_NO_EDGES   = 3'd2,
        VERDICT_WRONG_CNT  = 3'd3,
        VERDICT_DIST_OUT   = 3'd4,
        VERDICT_PERIOD_OUT = 3'd5
    } verdict_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_PULSES = 3'd0,
        CFG_TOF_MIN         = 3'd1,
        CFG_TOF_MAX         = 3'd2,
        CFG_PERIOD_MIN      = 3'd3,
        CFG_PERIOD_MAX      = 3'd4,
        CFG_BUZZER_TICKS    = 3'd5
    } cfg_idx_t;

    // Configuration reset values.
    localparam logic [PULSES_W-1:0] EXPECTED_PULSES_RST = 5'd8;
    localparam logic [TS_W-1:0]     TOF_MIN_RST         = 32'h0000_0000;
    localparam logic [TS_W-1:0]     TOF_MAX_RST         = 32'hFFFF_FFFF;
    localparam logic [TS_W-1:0]     PERIOD_MIN_RST      = 32'h0000_0000;
    localparam logic [TS_W-1:0]     PERIOD_MAX_RST      = 32'hFFFF_FFFF;
    localparam logic [BUZ_W-1:0]    BUZZER_TICKS_RST    = 16'd100;

endpackage

/* hdl/uev_evt_if.sv */
// Event channel: one item per timestamped event.
interface uev_evt_if;
    logic                         valid;
    logic                         ready;
    logic [uev_pkg::REQ_W-1:0]    req_type;
    logic [uev_pkg::TS_W-1:0]     timestamp;

    modport source (output valid, output req_type, output timestamp, input ready);
    modport sink   (input valid, input req_type, input timestamp, output ready);
endinterface

/* hdl/uev_res_if.sv */
// Result channel: one item per accepted event.
interface uev_res_if;
    logic                            valid;
    logic                            ready;
    logic [uev_pkg::VERDICT_W-1:0]   verdict;
    logic [uev_pkg::TS_W-1:0]        flight_time;
    logic                            buzzer_on;
    logic                            window_open;
    logic [uev_pkg::EDGES_W-1:0]     edges_seen;

    modport source (
        output valid, output verdict, output flight_time, output buzzer_on,
        output window_open, output edges_seen, input ready
    );
    modport sink (
        input valid, input verdict, input flight_time, input buzzer_on,
        input window_open, input edges_seen, output ready
    );
endinterface

/* hdl/uev_cfg_if.sv */
// Configuration write channel: register index and write data.
interface uev_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [uev_pkg::CFG_IDX_W-1:0]     index;
    logic [uev_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/ultrasonic_echo_validator_unit.sv */
// A result item appears in the cycle after its event item is accepted.
// Throughput: one event item per cycle; the single output register sets this
// figure and takes a new item whenever it is empty or being drained.
// Configuration writes are taken in every cycle.
// Reset (rst_n low, asynchronous) clears the event state and the output valid flag, but not the
// result payload, and loads the configuration registers with their default values.
`include "assert_macros.svh"

module ultrasonic_echo_validator_unit #(
    parameter int unsigned MAX_EDGES = uev_pkg::MAX_EDGES_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    uev_cfg_if.sink cfg,
    uev_evt_if.sink evt,
    uev_res_if.source res
);

    localparam int unsigned CNT_W = $clog2(MAX_EDGES + 1);
    localparam int unsigned CMP_W = (CNT_W > uev_pkg::PULSES_W) ? CNT_W : uev_pkg::PULSES_W;

    // Configuration registers.
    logic [uev_pkg::PULSES_W-1:0] exp_pulses_reg;
    logic [uev_pkg::TS_W-1:0]     tof_min_reg;
    logic [uev_pkg::TS_W-1:0]     tof_max_reg;
    logic [uev_pkg::TS_W-1:0]     per_min_reg;
    logic [uev_pkg::TS_W-1:0]     per_max_reg;
    logic [uev_pkg::BUZ_W-1:0]    buz_ticks_reg;

    // Event state.
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      open_reg, open_next;
    logic                      done_reg, done_next;
    logic [uev_pkg::TS_W-1:0]  burst_end_reg, burst_end_next;
    logic [uev_pkg::TS_W-1:0]  first_edge_reg, first_edge_next;
    logic [uev_pkg::TS_W-1:0]  last_edge_reg, last_edge_next;
    logic                      fault_reg, fault_next;
    logic                      buz_reg, buz_next;
    logic [uev_pkg::BUZ_W-1:0] buz_rem_reg, buz_rem_next;

    // Output register.
    logic                      res_valid_reg, res_valid_next;
    uev_pkg::verdict_t         out_verdict_reg, out_verdict_next;
    logic [uev_pkg::TS_W-1:0]  out_flight_reg, out_flight_next;
    logic                      out_buz_reg;
    logic                      out_open_reg;
    logic [uev_pkg::EDGES_W-1:0] out_edges_reg;

    // Datapath helpers.
    logic                      evt_fire;
    uev_pkg::req_t             req_code;
    logic [uev_pkg::TS_W-1:0]  period;
    logic [uev_pkg::TS_W-1:0]  flight_calc;
    logic [CNT_W-1:0]          cnt_inc;
    logic [CMP_W-1:0]          cnt_inc_ext;
    logic [CMP_W-1:0]          cnt_ext;
    logic [CMP_W-1:0]          cnt_next_ext;
    logic [CMP_W-1:0]          exp_ext;
    logic [uev_pkg::BUZ_W-1:0] buz_rem_dec;

    // Conditions watched by the assertions.
    logic                      eval_go;
    logic                      cycle_clear;
    logic                      out_accepted;
    logic                      no_flight;

    // Handshakes: the output register parts the two sides.
    assign evt_fire  = evt.valid && evt.ready;
    assign evt.ready = !res_valid_reg || res.ready;
    assign cfg.ready = 1'b1;

    assign req_code     = uev_pkg::req_t'(evt.req_type);
    assign period       = evt.timestamp - last_edge_reg;
    assign flight_calc  = first_edge_reg - burst_end_reg;
    assign cnt_inc      = cnt_reg + CNT_W'(1);
    assign cnt_inc_ext  = CMP_W'(cnt_inc);
    assign cnt_ext      = CMP_W'(cnt_reg);
    assign cnt_next_ext = CMP_W'(cnt_next);
    assign exp_ext      = CMP_W'(exp_pulses_reg);
    assign buz_rem_dec  = (buz_rem_reg != '0) ? (buz_rem_reg - uev_pkg::BUZ_W'(1)) : '0;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_pulses_reg <= uev_pkg::EXPECTED_PULSES_RST;
            tof_min_reg    <= uev_pkg::TOF_MIN_RST;
            tof_max_reg    <= uev_pkg::TOF_MAX_RST;
            per_min_reg    <= uev_pkg::PERIOD_MIN_RST;
            per_max_reg    <= uev_pkg::PERIOD_MAX_RST;
            buz_ticks_reg  <= uev_pkg::BUZZER_TICKS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (uev_pkg::cfg_idx_t'(cfg.index))
                uev_pkg::CFG_EXPECTED_PULSES: exp_pulses_reg <= cfg.data[uev_pkg::PULSES_W-1:0];
                uev_pkg::CFG_TOF_MIN:         tof_min_reg    <= cfg.data;
                uev_pkg::CFG_TOF_MAX:         tof_max_reg    <= cfg.data;
                uev_pkg::CFG_PERIOD_MIN:      per_min_reg    <= cfg.data;
                uev_pkg::CFG_PERIOD_MAX:      per_max_reg    <= cfg.data;
                uev_pkg::CFG_BUZZER_TICKS:    buz_ticks_reg  <= cfg.data[uev_pkg::BUZ_W-1:0];
                default:                      ;
            endcase
        end
    end

    // Event decode: next state and result for the item being accepted.
    always_comb
    begin
        cnt_next         = cnt_reg;
        open_next        = open_reg;
        done_next        = done_reg;
        burst_end_next   = burst_end_reg;
        first_edge_next  = first_edge_reg;
        last_edge_next   = last_edge_reg;
        fault_next       = fault_reg;
        buz_next         = buz_reg;
        buz_rem_next     = buz_rem_reg;
        out_verdict_next = uev_pkg::VERDICT_NONE;
        out_flight_next  = '0;

        if (evt_fire)
        begin
            case (req_code)
                uev_pkg::REQ_BURST_START:
                begin
                    open_next  = 1'b1;
                    cnt_next   = '0;
                    done_next  = 1'b0;
                    fault_next = 1'b0;
                end
                uev_pkg::REQ_BURST_END:
                begin
                    burst_end_next = evt.timestamp;
                    done_next      = 1'b1;
                end
                uev_pkg::REQ_ECHO_EDGE:
                begin
                    if (open_reg && (cnt_reg < CNT_W'(MAX_EDGES)))
                    begin
                        if (cnt_reg == '0)
                        begin
                            first_edge_next = evt.timestamp;
                        end
                        else if ((period < per_min_reg) || (period > per_max_reg))
                        begin
                            fault_next = 1'b1;
                        end
                        last_edge_next = evt.timestamp;
                        cnt_next       = cnt_inc;
                        if (cnt_inc_ext >= exp_ext)
                        begin
                            open_next = 1'b0;
                        end
                    end
                end
                uev_pkg::REQ_TICK:
                begin
                    if (buz_reg)
                    begin
                        buz_rem_next = buz_rem_dec;
                        if (buz_rem_dec == '0)
                        begin
                            buz_next = 1'b0;
                        end
                    end
                end
                uev_pkg::REQ_EVALUATE:
                begin
                    // Evaluation acts only on a closed window after a burst end; otherwise it leaves the state alone.
                    if (!open_reg && done_reg)
                    begin
                        if (cnt_reg == '0)
                        begin
                            out_verdict_next = uev_pkg::VERDICT_NO_EDGES;
                        end
                        else
                        begin
                            out_flight_next = flight_calc;
                            if (cnt_ext != exp_ext)
                            begin
                                out_verdict_next = uev_pkg::VERDICT_WRONG_CNT;
                            end
                            else if ((flight_calc < tof_min_reg) || (flight_calc > tof_max_reg))
                            begin
                                out_verdict_next = uev_pkg::VERDICT_DIST_OUT;
                            end
                            else if (fault_reg)
                            begin
                                out_verdict_next = uev_pkg::VERDICT_PERIOD_OUT;
                            end
                            else
                            begin
                                out_verdict_next = uev_pkg::VERDICT_ACCEPTED;
                                buz_next         = 1'b1;
                                buz_rem_next     = buz_ticks_reg;
                            end
                        end
                        cnt_next   = '0;
                        done_next  = 1'b0;
                        fault_next = 1'b0;
                    end
                end
                uev_pkg::REQ_STOP:
                begin
                    open_next    = 1'b0;
                    buz_next     = 1'b0;
                    buz_rem_next = '0;
                end
                default:
                begin
                    // Unused request codes leave the state alone.
                end
            endcase
        end
    end

    // Output valid: set on an accepted item, cleared when the item is taken.
    always_comb
    begin
        if (evt_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            open_reg       <= 1'b0;
            done_reg       <= 1'b0;
            burst_end_reg  <= '0;
            first_edge_reg <= '0;
            last_edge_reg  <= '0;
            fault_reg      <= 1'b0;
            buz_reg        <= 1'b0;
            buz_rem_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            open_reg       <= open_next;
            done_reg       <= done_next;
            burst_end_reg  <= burst_end_next;
            first_edge_reg <= first_edge_next;
            last_edge_reg  <= last_edge_next;
            fault_reg      <= fault_next;
            buz_reg        <= buz_next;
            buz_rem_reg    <= buz_rem_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Result payload, loaded when an item is accepted.
    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            out_verdict_reg <= out_verdict_next;
            out_flight_reg  <= out_flight_next;
            out_buz_reg     <= buz_next;
            out_open_reg    <= open_next;
            out_edges_reg   <= cnt_next_ext[uev_pkg::EDGES_W-1:0];
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.verdict     = out_verdict_reg;
    assign res.flight_time = out_flight_reg;
    assign res.buzzer_on   = out_buz_reg;
    assign res.window_open = out_open_reg;
    assign res.edges_seen  = out_edges_reg;

    // Conditions for the checks below.
    assign eval_go      = evt_fire && (req_code == uev_pkg::REQ_EVALUATE) && !open_reg && done_reg;
    assign cycle_clear  = (cnt_reg == '0) && !done_reg && !fault_reg;
    assign out_accepted = res_valid_reg && (out_verdict_reg == uev_pkg::VERDICT_ACCEPTED);
    assign no_flight    = res_valid_reg &&
                          ((out_verdict_reg == uev_pkg::VERDICT_NONE) ||
                           (out_verdict_reg == uev_pkg::VERDICT_NO_EDGES));

    // The edge counter never passes its capacity.
    `UEV_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(MAX_EDGES), "edge count above capacity")

    // A ready evaluate clears the count, the burst-end mark and the period fault.
    `UEV_ASSERT_NEXT(a_eval_clears, eval_go, cycle_clear, "evaluate did not clear the cycle")

    // An accepted echo always reports the buzzer as on.
    `UEV_ASSERT_IMPL(a_accept_buzz, out_accepted, out_buz_reg, "accepted echo without buzzer")

    // No flight time goes out with a verdict that carries none.
    `UEV_ASSERT_IMPL(a_flight_zero, no_flight, out_flight_reg == '0, "stray flight time")

endmodule
